FILE: design/asp_pkg.sv
// asp_pkg: shared constants and types for the arcsinh pixel stretch core.
// Used by asp_asinh and arcsinh_pixel_stretch_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package asp_pkg;

  localparam int NUM_CH      = 3;
  localparam int SAMPLE_W    = 16;
  localparam int XDIV_STEPS  = 32;  // quotient bits of x = s*n
  localparam int SQRT_STEPS  = 32;  // root bits of sqrt(x*x + 1)
  localparam int LOG_STEPS   = 32;  // fraction bits of log2
  localparam int QDIV_STEPS  = 16;  // quotient bits of the output ratio
  localparam int ASINH_W     = 36;  // ln result, Q32
  // square, sqrt steps, add, normalize search, shift, log steps, ln2 scale
  localparam int ASINH_LAT   = SQRT_STEPS + LOG_STEPS + 5;
  // entry/div0, x divide, asinh, ratio load, ratio divide, output register
  localparam int PIPE_DEPTH  = 1 + XDIV_STEPS + ASINH_LAT + 1 + QDIV_STEPS + 1;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [1:0] {
    REG_BLACK    = 2'd0,
    REG_WHITE    = 2'd1,
    REG_STRENGTH = 2'd2
  } asp_reg_t;

  typedef struct packed {
    logic en;    // advance the pipeline
    logic fine;  // x in Q31 (strength below 1.0), else Q24
  } asp_ctl_t;

endpackage

`default_nettype wire

FILE: design/asp_asinh.sv
// asp_asinh: pipelined asinh(x) for x in Q31 or Q24, result ln(w) in Q32.
// Stages: square, 32 sqrt digits, add, normalize, 32 log2 squarings, ln2 scale.
// Depends on asp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asp_asinh import asp_pkg::*; (
  input  wire logic               clk,
  input  wire asp_ctl_t           ctl,
  input  wire logic [31:0]        x_i,
  output logic      [ASINH_W-1:0] asinh_o
);

  logic [34:0] sq_rem_r  [SQRT_STEPS+1];
  logic [31:0] sq_root_r [SQRT_STEPS+1];
  logic [63:0] sq_rad_r  [SQRT_STEPS+1];
  logic [31:0] sq_x_r    [SQRT_STEPS+1];
  logic [34:0] sq_rem_nxt  [SQRT_STEPS+1];
  logic [31:0] sq_root_nxt [SQRT_STEPS+1];
  logic [63:0] sq_rad_nxt  [SQRT_STEPS+1];

  logic [40:0] wq_r;
  logic [40:0] nz_wq_r;
  logic [3:0]  nz_k_r;
  logic [3:0]  nz_k_nxt;

  logic [31:0] lg_m_r    [LOG_STEPS+1];
  logic [31:0] lg_frac_r [LOG_STEPS+1];
  logic [3:0]  lg_k_r    [LOG_STEPS+1];
  logic [31:0] lg_m_nxt    [LOG_STEPS+1];
  logic [31:0] lg_frac_nxt [LOG_STEPS+1];

  logic [63:0] ln_r;
  logic [63:0] rad_bias;
  logic [32:0] w_sum;
  logic [31:0] lg_word;

  assign rad_bias = ctl.fine ? 64'h4000_0000_0000_0000 : 64'h0001_0000_0000_0000;
  assign w_sum    = {1'b0, sq_x_r[SQRT_STEPS]} + {1'b0, sq_root_r[SQRT_STEPS]};
  assign lg_word  = {lg_k_r[LOG_STEPS], lg_frac_r[LOG_STEPS][31:4]};
  assign asinh_o  = ln_r[63:28];

  // restoring square root, two radicand bits per stage
  always_comb begin
    logic [36:0] cur;
    logic [36:0] trial;
    logic        ge;
    sq_rem_nxt[0]  = '0;
    sq_root_nxt[0] = '0;
    sq_rad_nxt[0]  = '0;
    for (int j = 1; j <= SQRT_STEPS; j++) begin
      cur   = {sq_rem_r[j-1], sq_rad_r[j-1][63:62]};
      trial = {3'b000, sq_root_r[j-1], 2'b01};
      ge    = (cur >= trial);
      sq_rem_nxt[j]  = ge ? 35'(cur - trial) : cur[34:0];
      sq_root_nxt[j] = {sq_root_r[j-1][30:0], ge};
      sq_rad_nxt[j]  = {sq_rad_r[j-1][61:0], 2'b00};
    end
  end

  // leading one of the word above bit 31 gives the integer part of log2
  always_comb begin
    nz_k_nxt = '0;
    for (int b = 0; b < 9; b++) begin
      if (wq_r[32+b]) nz_k_nxt = 4'(b + 1);
    end
  end

  // log2 fraction by repeated squaring of the Q31 mantissa
  always_comb begin
    logic [63:0] sq;
    logic [32:0] top;
    lg_m_nxt[0]    = '0;
    lg_frac_nxt[0] = '0;
    for (int j = 1; j <= LOG_STEPS; j++) begin
      sq  = {32'b0, lg_m_r[j-1]} * {32'b0, lg_m_r[j-1]};
      top = sq[63:31];
      lg_m_nxt[j]    = top[32] ? top[32:1] : top[31:0];
      lg_frac_nxt[j] = lg_frac_r[j-1];
      lg_frac_nxt[j][32-j] = top[32];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_rad_r[0]  <= ({32'b0, x_i} * {32'b0, x_i}) + rad_bias;
      sq_x_r[0]    <= x_i;
      for (int j = 1; j <= SQRT_STEPS; j++) begin
        sq_rem_r[j]  <= sq_rem_nxt[j];
        sq_root_r[j] <= sq_root_nxt[j];
        sq_rad_r[j]  <= sq_rad_nxt[j];
        sq_x_r[j]    <= sq_x_r[j-1];
      end
      wq_r    <= ctl.fine ? {8'b0, w_sum} : {w_sum, 7'b0};
      nz_wq_r <= wq_r;
      nz_k_r  <= nz_k_nxt;
      lg_m_r[0]    <= 32'(nz_wq_r >> nz_k_r);
      lg_frac_r[0] <= '0;
      lg_k_r[0]    <= nz_k_r;
      for (int j = 1; j <= LOG_STEPS; j++) begin
        lg_m_r[j]    <= lg_m_nxt[j];
        lg_frac_r[j] <= lg_frac_nxt[j];
        lg_k_r[j]    <= lg_k_r[j-1];
      end
      ln_r <= {32'b0, lg_word} * {32'b0, LN2_Q32};
    end
  end

endmodule

`default_nettype wire

FILE: design/arcsinh_pixel_stretch_core.sv
// arcsinh_pixel_stretch_core: per-pixel arcsinh display stretch, three channels.
// Depends on asp_pkg and asp_asinh (three sample lanes plus one lane for the scale).
//
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tdata[47:0] = red_in, green_in, blue_in
//  out_    | out | tvalid/tready      | tdata[47:0] = red_out, green_out, blue_out
//  cfg_    | in  | we (no back-press) | index[1:0], wdata[15:0]
//
// One pixel per clock sustained while out_tready is high; out_tvalid rises when the
// accepted pixel's valid bit reaches the last of the PIPE_DEPTH valid stages.
// The 32-bit x divide, the sqrt and the log2 squaring chains set the depth.
// rst_n clears the valid bits and loads black 0, white 65535, strength 1.0.
// A held output with out_tready low freezes the whole pipeline; in_tready drops
// only then, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module arcsinh_pixel_stretch_core import asp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,    // red_in[15:0], green_in[31:16], blue_in[47:32]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,   // red_out[15:0], green_out[31:16], blue_out[47:32]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] black_r, white_r, strength_r;
  logic        pipe_en;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [NUM_CH-1:0]     zero_r [PIPE_DEPTH];
  logic [NUM_CH-1:0]     zero_nxt;

  logic [15:0] s_eff;
  logic        fine;
  logic [15:0] range_d;
  logic        range_ok;
  logic [31:0] xs;
  asp_ctl_t    lane_ctl;

  logic [15:0] dv_rem_r [NUM_CH][XDIV_STEPS+1];
  logic [31:0] dv_lo_r  [NUM_CH][XDIV_STEPS+1];
  logic [15:0] dv_rem_nxt [NUM_CH][XDIV_STEPS+1];
  logic [31:0] dv_lo_nxt  [NUM_CH][XDIV_STEPS+1];

  logic [31:0]        lane_x [NUM_CH+1];
  logic [ASINH_W-1:0] lane_y [NUM_CH+1];

  logic [ASINH_W-1:0] qd_rem_r [NUM_CH][QDIV_STEPS+1];
  logic [15:0]        qd_lo_r  [NUM_CH][QDIV_STEPS+1];
  logic [ASINH_W-1:0] qd_rem_nxt [NUM_CH][QDIV_STEPS+1];
  logic [15:0]        qd_lo_nxt  [NUM_CH][QDIV_STEPS+1];
  logic [ASINH_W-1:0] qd_den_r [QDIV_STEPS+1];
  logic [47:0]        out_data_r;

  assign pipe_en    = !vld_r[PIPE_DEPTH-1] || out_tready;
  assign in_tready  = pipe_en;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];
  assign out_tdata  = out_data_r;

  assign s_eff    = (strength_r == 16'd0) ? 16'd1 : strength_r;
  assign fine     = (s_eff[15:8] == 8'd0);
  assign range_ok = (white_r > black_r);
  assign range_d  = white_r - black_r;
  assign xs       = fine ? {s_eff[8:0], 23'b0} : {s_eff, 16'b0};
  assign lane_ctl = '{en: pipe_en, fine: fine};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_r    <= 16'd0;
      white_r    <= 16'hFFFF;
      strength_r <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLACK:    black_r    <= cfg_wdata;
        REG_WHITE:    white_r    <= cfg_wdata;
        REG_STRENGTH: strength_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // entry: s*diff shifted into the dividend; the high part is already below d.
  // then x = dividend / d, one quotient bit per stage
  always_comb begin
    logic [15:0] v;
    logic [15:0] diff;
    logic [31:0] prod;
    logic [54:0] dvd;
    logic [16:0] cur;
    logic        ge;
    for (int c = 0; c < NUM_CH; c++) begin
      v           = in_tdata[SAMPLE_W*c +: SAMPLE_W];
      zero_nxt[c] = !range_ok || (v <= black_r);
      diff        = zero_nxt[c] ? 16'd0 : ((v >= white_r) ? range_d : 16'(v - black_r));
      prod        = {16'b0, s_eff} * {16'b0, diff};
      dvd         = {23'b0, prod} << (fine ? 23 : 16);
      dv_rem_nxt[c][0] = dvd[47:32];
      dv_lo_nxt[c][0]  = dvd[31:0];
      for (int j = 1; j <= XDIV_STEPS; j++) begin
        cur = {dv_rem_r[c][j-1], dv_lo_r[c][j-1][31]};
        ge  = (cur >= {1'b0, range_d});
        dv_rem_nxt[c][j] = ge ? 16'(cur - {1'b0, range_d}) : cur[15:0];
        dv_lo_nxt[c][j]  = {dv_lo_r[c][j-1][30:0], ge};
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) lane_x[c] = dv_lo_r[c][XDIV_STEPS];
    lane_x[NUM_CH] = xs;
  end

  for (genvar l = 0; l <= NUM_CH; l++) begin : g_lane
    asp_asinh u_asinh (
      .clk     (clk),
      .ctl     (lane_ctl),
      .x_i     (lane_x[l]),
      .asinh_o (lane_y[l])
    );
  end

  // output = (num*65535 + den/2) / den; num never exceeds den
  always_comb begin
    logic [52:0]        dvd;
    logic [ASINH_W:0]   cur;
    logic               ge;
    for (int c = 0; c < NUM_CH; c++) begin
      dvd = ({17'b0, lane_y[c]} << 16) - {17'b0, lane_y[c]}
            + {18'b0, lane_y[NUM_CH][ASINH_W-1:1]};
      qd_rem_nxt[c][0] = dvd[51:16];
      qd_lo_nxt[c][0]  = dvd[15:0];
      for (int j = 1; j <= QDIV_STEPS; j++) begin
        cur = {qd_rem_r[c][j-1], qd_lo_r[c][j-1][15]};
        ge  = (cur >= {1'b0, qd_den_r[j-1]});
        qd_rem_nxt[c][j] = ge ? ASINH_W'(cur - {1'b0, qd_den_r[j-1]}) : cur[ASINH_W-1:0];
        qd_lo_nxt[c][j]  = {qd_lo_r[c][j-1][14:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      zero_r[0] <= zero_nxt;
      for (int s = 1; s < PIPE_DEPTH; s++) zero_r[s] <= zero_r[s-1];
      for (int c = 0; c < NUM_CH; c++) begin
        for (int j = 0; j <= XDIV_STEPS; j++) begin
          dv_rem_r[c][j] <= dv_rem_nxt[c][j];
          dv_lo_r[c][j]  <= dv_lo_nxt[c][j];
        end
        for (int j = 0; j <= QDIV_STEPS; j++) begin
          qd_rem_r[c][j] <= qd_rem_nxt[c][j];
          qd_lo_r[c][j]  <= qd_lo_nxt[c][j];
        end
        out_data_r[SAMPLE_W*c +: SAMPLE_W] <=
          (zero_r[PIPE_DEPTH-2][c] || qd_den_r[QDIV_STEPS] == '0) ?
          16'd0 : qd_lo_r[c][QDIV_STEPS];
      end
      qd_den_r[0] <= lane_y[NUM_CH];
      for (int j = 1; j <= QDIV_STEPS; j++) qd_den_r[j] <= qd_den_r[j-1];
    end
  end

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

  a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[PIPE_DEPTH-2] |-> qd_den_r[QDIV_STEPS] != '0)
    else $error("asinh(s) scale is zero for a live pixel");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

FILE: tb/arcsinh_pixel_stretch_core_tb.sv
// Self-checking bench for arcsinh_pixel_stretch_core: three-channel arcsinh stretch.
// Depends on asp_pkg and the core; a built-in fixed-point predictor checks every pixel.
`timescale 1ns / 1ps

module arcsinh_pixel_stretch_core_tb;
  import asp_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;  // unmapped index, writes are dropped
  localparam int         DRAIN_CYCLES = 140;
  localparam int         WDOG_LIMIT = 3000;
  localparam int         LONG_HOLD = 400;

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_BLACK;
  logic [15:0] cfg_wdata = '0;

  arcsinh_pixel_stretch_core DUT (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // bench copy of the register file
  logic [15:0] blk_lvl = 16'd0, wht_lvl = 16'hFFFF, strength = 16'd256;

  pixel_t pix_q[$];
  pixel_t stretched_q[$];
  int     errors = 0, n_in = 0, n_out = 0, idle_cycles = 0, n_queued = 0;
  bit     hold_armed = 1'b1;
  int     hold_left = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // ln(x + sqrt(x*x+1)) in Q32 for x in QF
  function automatic logic [63:0] ln_asinh(logic [63:0] x, int f);
    logic [63:0] w, wq, m, frac, lg;
    int k;
    w = x + int_sqrt(x * x + (64'd1 << (2 * f)));
    wq = w << (31 - f);
    k = 0;
    frac = 0;
    while (k < 40 && (wq >> k) >= (64'd1 << 32)) k++;
    m = wq >> k;
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[31-i] = 1'b1;
      end
    end
    lg = ((64'(k) << 32) | frac) >> 4;
    return (lg * 64'(LN2_Q32)) >> 28;
  endfunction

  function automatic logic [15:0] stretch_sample(logic [15:0] v);
    logic [63:0] s, d, diff, xn, xs, num, den, q;
    int f;
    s = (strength == 0) ? 64'd1 : 64'(strength);
    f = (s < 256) ? 31 : 24;
    if (wht_lvl <= blk_lvl || v <= blk_lvl) return 16'd0;
    d = 64'(wht_lvl - blk_lvl);
    diff = (v >= wht_lvl) ? d : 64'(v - blk_lvl);
    xs = s << (f - 8);
    xn = ((s * diff) << (f - 8)) / d;
    num = ln_asinh(xn, f);
    den = ln_asinh(xs, f);
    if (den == 0) return 16'd0;
    q = (num * 64'd65535 + den / 2) / den;
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH pixel %0d %s: got %0d want %0d", n_out, what, got, want);
    errors++;
  endtask

  task automatic queue_pixel(pixel_t px);
    pix_q.insert(pix_q.size(), px);
    n_queued++;
  endtask

  // sender: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pix_q.size() > 0) begin
        in_tdata <= pix_q.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off early in a long phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_armed && n_in > 500) begin
      hold_armed <= 1'b0;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (n_in[8]) begin
      out_tready <= 1'b1;  // stretches with no stalls
    end else begin
      out_tready <= ($urandom_range(0, 9) < 7);
    end
  end

  // predictor and checker
  always @(posedge clk) begin
    pixel_t px, got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        px = in_tdata;
        want.red = stretch_sample(px.red);
        want.green = stretch_sample(px.green);
        want.blue = stretch_sample(px.blue);
        stretched_q.insert(stretched_q.size(), want);
        n_in++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (stretched_q.size() == 0) begin
          $display("UNEXPECTED pixel %0d: %h", n_out, out_tdata);
          errors++;
        end else begin
          want = stretched_q.pop_front();
          if (got.red !== want.red) report_mismatch("red", got.red, want.red);
          if (got.green !== want.green) report_mismatch("green", got.green, want.green);
          if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
        end
        n_out++;
      end
      idle_cycles <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ? 0
                     : idle_cycles + 1;
      if (idle_cycles > WDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLACK:    blk_lvl = val;
      REG_WHITE:    wht_lvl = val;
      REG_STRENGTH: strength = val;
      default: ;
    endcase
  endtask

  // every queued pixel must have come back before registers change
  task automatic wait_drained();
    while (n_out < n_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    int lo, hi;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
      default: begin
        lo = (int'(blk_lvl) > 2) ? int'(blk_lvl) - 2 : 0;
        hi = (int'(wht_lvl) < 65533) ? int'(wht_lvl) + 2 : 65535;
        if (hi < lo) return 16'($urandom);
        return 16'($urandom_range(lo, hi));
      end
    endcase
  endfunction

  task automatic push_edge_pixels();
    logic [15:0] vals[$];
    pixel_t px;
    vals = {16'd0, 16'hFFFF, blk_lvl, wht_lvl, blk_lvl + 16'd1, blk_lvl - 16'd1,
            wht_lvl + 16'd1, wht_lvl - 16'd1, 16'h5555, 16'hAAAA};
    foreach (vals[i]) begin
      px.red = vals[i];
      px.green = vals[(i + 3) % vals.size()];
      px.blue = vals[(i + 7) % vals.size()];
      queue_pixel(px);
    end
  endtask

  task automatic run_phase(logic [15:0] b, logic [15:0] w, logic [15:0] s, int n_rand);
    pixel_t px;
    write_reg(REG_BLACK, b);
    write_reg(REG_WHITE, w);
    write_reg(REG_STRENGTH, s);
    push_edge_pixels();
    repeat (n_rand) begin
      px.red = pick_sample();
      px.green = pick_sample();
      px.blue = pick_sample();
      queue_pixel(px);
    end
    wait_drained();  // run_phase waits here until every pixel is back
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // reset defaults first, no writes
    push_edge_pixels();
    wait_drained();
    write_reg(REG_NONE, 16'h1234);  // must be ignored
    run_phase(16'd0, 16'hFFFF, 16'd256, 150);
    run_phase(16'd1000, 16'd50000, 16'd1, 150);      // smallest strength
    run_phase(16'd0, 16'hFFFF, 16'hFFFF, 150);       // largest strength
    run_phase(16'd300, 16'd301, 16'd0, 150);         // zero strength, one-step range
    run_phase(16'd40000, 16'd40000, 16'd512, 60);    // empty range
    run_phase(16'hFFFF, 16'd0, 16'd700, 60);         // inverted range
    run_phase(16'd100, 16'd65000, 16'd255, 150);
    repeat (8) begin
      run_phase(16'($urandom_range(0, 20000)), 16'($urandom_range(20000, 65535)),
                16'($urandom), 100);
    end
    $display("covered %0d pixels in %0d results across 16 register settings", n_in, n_out);
    $display("settings include empty and inverted ranges, strengths 0, 1, 255 and 65535");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/asp_pkg.sv
design/asp_asinh.sv
design/arcsinh_pixel_stretch_core.sv
tb/arcsinh_pixel_stretch_core_tb.sv
